// File: rtl/volume_surface_depth_shader_assert.svh
// Assertion macros for the volume surface depth shader checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef VOLUME_SURFACE_DEPTH_SHADER_ASSERT_SVH
`define VOLUME_SURFACE_DEPTH_SHADER_ASSERT_SVH

// same-cycle implication
`define VSDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VSDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/vsds_pkg.sv
// Shared types and constants for the volume surface depth shader.
// No dependencies.
`timescale 1ns / 1ps

package vsds_pkg;

  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  localparam logic [2:0] REG_THRESHOLD  = 3'd0;
  localparam logic [2:0] REG_RAY_LENGTH = 3'd1;
  localparam logic [2:0] REG_RAYS       = 3'd2;
  localparam logic [2:0] REG_DIST_GAIN  = 3'd3;
  localparam logic [2:0] REG_DIST_OFFS  = 3'd4;
  localparam logic [2:0] REG_REFL_GAIN  = 3'd5;
  localparam logic [2:0] REG_ATTEN      = 3'd6;
  localparam logic [2:0] REG_BACKGROUND = 3'd7;

  localparam int unsigned DIV_STEPS = 32;

  typedef struct packed {
    logic signed [15:0] voxel_value;
    logic               frame_start;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
  } out_t;

  typedef struct packed {
    logic signed [15:0] threshold;
    logic [10:0]        ray_length;
    logic [9:0]         rays_per_slice;
    logic signed [15:0] distance_gain;
    logic signed [15:0] distance_offset;
    logic signed [15:0] reflect_gain;
    logic [15:0]        attenuation;
    logic [7:0]         background;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_SQUARE,
    ST_FTSUM,
    ST_SCALE,
    ST_SQRT,
    ST_DINIT,
    ST_DIV,
    ST_SUM,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic accept;
    logic read;
    logic diff;
    logic square;
    logic ftsum;
    logic scale;
    logic sqrt_step;
    logic dinit;
    logic div_step;
    logic sum;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic       ray_end;
    logic [1:0] slice_sel;
    logic       tile_ok;
    logic       sqrt_last;
    logic       div_last;
    logic       out_free;
  } sts_t;

endpackage

// File: rtl/vsds_cfg.sv
// APB register file for the volume surface depth shader.
// Depends on vsds_pkg.
`timescale 1ns / 1ps

module vsds_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vsds_pkg::PADDR_W-1:0] paddr,
  input  logic [vsds_pkg::PDATA_W-1:0] pwdata,
  output logic [vsds_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output vsds_pkg::cfg_t               cfg_o
);
  import vsds_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (idx)
        REG_THRESHOLD:  cfg_d.threshold       = pwdata[15:0];
        REG_RAY_LENGTH: cfg_d.ray_length      = pwdata[10:0];
        REG_RAYS:       cfg_d.rays_per_slice  = pwdata[9:0];
        REG_DIST_GAIN:  cfg_d.distance_gain   = pwdata[15:0];
        REG_DIST_OFFS:  cfg_d.distance_offset = pwdata[15:0];
        REG_REFL_GAIN:  cfg_d.reflect_gain    = pwdata[15:0];
        REG_ATTEN:      cfg_d.attenuation     = pwdata[15:0];
        REG_BACKGROUND: cfg_d.background      = pwdata[7:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_THRESHOLD:  prdata = {16'b0, cfg_q.threshold};
      REG_RAY_LENGTH: prdata = {21'b0, cfg_q.ray_length};
      REG_RAYS:       prdata = {22'b0, cfg_q.rays_per_slice};
      REG_DIST_GAIN:  prdata = {16'b0, cfg_q.distance_gain};
      REG_DIST_OFFS:  prdata = {16'b0, cfg_q.distance_offset};
      REG_REFL_GAIN:  prdata = {16'b0, cfg_q.reflect_gain};
      REG_ATTEN:      prdata = {16'b0, cfg_q.attenuation};
      REG_BACKGROUND: prdata = {24'b0, cfg_q.background};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q                 <= '0;
      cfg_q.ray_length      <= 11'd1024;
      cfg_q.rays_per_slice  <= 10'd512;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: rtl/vsds_ctrl.sv
// Sequencer for the volume surface depth shader: voxel intake, then the
// per-ray shading steps. Depends on vsds_pkg.
`timescale 1ns / 1ps

module vsds_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  vsds_pkg::sts_t sts_i,
  output vsds_pkg::cmd_t cmd_o
);
  import vsds_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i && sts_i.ray_end) state_d = ST_READ;
      ST_READ: begin
        case (sts_i.slice_sel)
          2'd0:    state_d = ST_IDLE;
          2'd1:    state_d = ST_EMIT;
          default: state_d = ST_DIFF;
        endcase
      end
      ST_DIFF:   state_d = sts_i.tile_ok ? ST_SQUARE : ST_EMIT;
      ST_SQUARE: state_d = ST_FTSUM;
      ST_FTSUM:  state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_SQRT;
      ST_SQRT:   if (sts_i.sqrt_last) state_d = ST_DINIT;
      ST_DINIT:  state_d = ST_DIV;
      ST_DIV:    if (sts_i.div_last) state_d = ST_SUM;
      ST_SUM:    state_d = ST_EMIT;
      ST_EMIT:   if (sts_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_READ:   cmd_o.read      = 1'b1;
      ST_DIFF:   cmd_o.diff      = 1'b1;
      ST_SQUARE: cmd_o.square    = 1'b1;
      ST_FTSUM:  cmd_o.ftsum     = 1'b1;
      ST_SCALE:  cmd_o.scale     = 1'b1;
      ST_SQRT:   cmd_o.sqrt_step = 1'b1;
      ST_DINIT:  cmd_o.dinit     = 1'b1;
      ST_DIV:    cmd_o.div_step  = 1'b1;
      ST_SUM:    cmd_o.sum       = 1'b1;
      ST_EMIT:   cmd_o.emit      = sts_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/vsds_dp.sv
// Datapath of the volume surface depth shader: ray counters, distance
// memory, tile math with bit-serial root and divider, output register.
// Depends on vsds_pkg.
`timescale 1ns / 1ps

module vsds_dp #(
  parameter int unsigned MAX_RAY_LENGTH = 1024,
  parameter int unsigned MAX_RAYS       = 512
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  vsds_pkg::cfg_t cfg_i,
  input  vsds_pkg::in_t  in_data_i,
  input  vsds_pkg::cmd_t cmd_i,
  output vsds_pkg::sts_t sts_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output vsds_pkg::out_t out_data_o
);
  import vsds_pkg::*;

  localparam int unsigned DW    = $clog2(MAX_RAY_LENGTH + 1);
  localparam int unsigned RW    = $clog2(MAX_RAYS);
  localparam int unsigned RCW   = $clog2(MAX_RAYS + 1);
  localparam int unsigned SQW   = 2 * DW;
  localparam int unsigned FTW   = SQW + 1;
  localparam int unsigned QW    = FTW + 17;
  localparam int unsigned XW    = QW + 16;
  localparam int unsigned SW    = XW / 2;
  localparam int unsigned GDW   = DW + 17;
  localparam int unsigned SHW   = DW + 19;
  localparam int unsigned NSTEP = (SW > DIV_STEPS) ? SW : DIV_STEPS;
  localparam int unsigned CNTW  = $clog2(NSTEP);

  // limits after clamping
  logic [DW-1:0]  len_c;
  logic [RCW-1:0] rays_c;

  always_comb begin
    if (cfg_i.ray_length == 11'd0)
      len_c = DW'(1);
    else if (32'(cfg_i.ray_length) > 32'(MAX_RAY_LENGTH))
      len_c = DW'(MAX_RAY_LENGTH);
    else
      len_c = DW'(cfg_i.ray_length);
    if (cfg_i.rays_per_slice == 10'd0)
      rays_c = RCW'(1);
    else if (32'(cfg_i.rays_per_slice) > 32'(MAX_RAYS))
      rays_c = RCW'(MAX_RAYS);
    else
      rays_c = RCW'(cfg_i.rays_per_slice);
  end

  // ray search and counters
  logic [DW-1:0] sc_q, hit_q, l_q, d_q;
  logic [RW-1:0] rc_q, col_q;
  logic [1:0]    sl_q, ssel_q;
  logic          edge_q, last_q;

  logic          fs;
  logic [DW-1:0] sc_p, hit_p, sc_inc, hit_n;
  logic [RW-1:0] rc_p, rc_e;
  logic [RCW-1:0] rc_nx;
  logic [1:0]    sl_p;
  logic          ray_end;

  assign fs     = in_data_i.frame_start;
  assign sc_p   = fs ? '0 : sc_q;
  assign hit_p  = fs ? '0 : hit_q;
  assign rc_p   = fs ? '0 : rc_q;
  assign sl_p   = fs ? 2'd0 : sl_q;
  assign rc_e   = (RCW'(rc_p) >= rays_c) ? '0 : rc_p;
  assign rc_nx  = RCW'(rc_e) + RCW'(1);
  assign sc_inc = sc_p + DW'(1);
  assign hit_n  = (hit_p == '0 && in_data_i.voxel_value >= cfg_i.threshold) ? sc_inc : hit_p;
  assign ray_end = sc_inc >= len_c;

  // previous slice distances
  logic [DW-1:0] mem [MAX_RAYS];
  logic [DW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      p_q        <= mem[col_q];
      mem[col_q] <= d_q;
    end
  end

  // tile arithmetic
  logic signed [DW:0]  a_q, b_q;
  logic signed [GDW-1:0] gd_q;
  logic [SQW-1:0]      asq_q, bsq_q;
  logic [FTW-1:0]      ft_q;
  logic [XW-1:0]       x_q;
  logic [SW:0]         rem_q;
  logic [SW-1:0]       root_q;
  logic [31:0]         num_q;
  logic [SW-1:0]       drem_q;
  logic                neg_q, bg_q;
  logic [CNTW-1:0]     cnt_q;
  logic signed [SHW-1:0] shade_q;

  logic                tile_ok;
  logic [DW:0]         a_neg, b_neg;
  logic [DW-1:0]       am, bm;
  logic [QW-1:0]       qv;
  logic [SW+2:0]       rem_sh, trial;
  logic [SW:0]         drs;
  logic [15:0]         rgm;
  logic signed [SHW-1:0] tq, term;
  logic signed [GDW-1:0] ge, de;
  logic [7:0]          sat_px;

  assign tile_ok = edge_q && p_q != '0 && l_q != '0 && d_q != '0;
  assign a_neg   = -a_q;
  assign b_neg   = -b_q;
  assign am      = a_q[DW] ? a_neg[DW-1:0] : a_q[DW-1:0];
  assign bm      = b_q[DW] ? b_neg[DW-1:0] : b_q[DW-1:0];
  assign qv      = QW'(17'h10000) + QW'(cfg_i.attenuation) * QW'(ft_q);
  assign rem_sh  = {rem_q, x_q[XW-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign drs     = {drem_q, num_q[31]};
  assign rgm     = cfg_i.reflect_gain[15] ? 16'(-cfg_i.reflect_gain) : cfg_i.reflect_gain;
  assign tq      = $signed({{(SHW-17){1'b0}}, num_q[16:0]});
  assign term    = neg_q ? -tq : tq;
  assign ge      = GDW'(cfg_i.distance_gain);
  assign de      = $signed({{(GDW-DW){1'b0}}, d_q});

  always_comb begin
    if (shade_q[SHW-1])
      sat_px = 8'd0;
    else if (|shade_q[SHW-2:16])
      sat_px = 8'd255;
    else
      sat_px = shade_q[15:8];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) bg_q <= (ssel_q == 2'd1);
    if (cmd_i.diff) begin
      a_q  <= $signed({1'b0, p_q}) - $signed({1'b0, l_q});
      b_q  <= $signed({1'b0, p_q}) - $signed({1'b0, d_q});
      gd_q <= ge * de;
      bg_q <= !tile_ok;
    end
    if (cmd_i.square) begin
      asq_q <= SQW'(am) * SQW'(am);
      bsq_q <= SQW'(bm) * SQW'(bm);
    end
    if (cmd_i.ftsum) ft_q <= FTW'(asq_q) + FTW'(bsq_q);
    if (cmd_i.scale) begin
      x_q    <= {qv, 16'b0};
      rem_q  <= '0;
      root_q <= '0;
    end
    if (cmd_i.sqrt_step) begin
      x_q <= x_q << 2;
      if (rem_sh >= trial) begin
        rem_q  <= (SW+1)'(rem_sh - trial);
        root_q <= {root_q[SW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[SW:0];
        root_q <= {root_q[SW-2:0], 1'b0};
      end
    end
    if (cmd_i.dinit) begin
      num_q  <= {rgm, 16'b0};
      neg_q  <= cfg_i.reflect_gain[15];
      drem_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (drs >= {1'b0, root_q}) begin
        drem_q <= SW'(drs - {1'b0, root_q});
        num_q  <= {num_q[30:0], 1'b1};
      end else begin
        drem_q <= drs[SW-1:0];
        num_q  <= {num_q[30:0], 1'b0};
      end
    end
    if (cmd_i.sum) shade_q <= SHW'(gd_q) + SHW'(cfg_i.distance_offset) + term;
  end

  // control registers
  logic out_valid_q;
  out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q        <= '0;
      hit_q       <= '0;
      rc_q        <= '0;
      sl_q        <= 2'd0;
      l_q         <= '0;
      d_q         <= '0;
      col_q       <= '0;
      ssel_q      <= 2'd0;
      edge_q      <= 1'b0;
      last_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cmd_i.accept) begin
        if (fs) l_q <= '0;
        if (ray_end) begin
          sc_q   <= '0;
          hit_q  <= '0;
          d_q    <= hit_n;
          col_q  <= rc_e;
          ssel_q <= sl_p;
          edge_q <= (rc_e != '0) && (rc_nx < rays_c);
          last_q <= rc_nx == rays_c;
          if (rc_nx >= rays_c) begin
            rc_q <= '0;
            sl_q <= (sl_p == 2'd2) ? 2'd2 : sl_p + 2'd1;
          end else begin
            rc_q <= RW'(rc_nx);
            sl_q <= sl_p;
          end
        end else begin
          sc_q  <= sc_inc;
          hit_q <= hit_n;
          rc_q  <= rc_e;
          sl_q  <= sl_p;
        end
      end
      if (cmd_i.diff) l_q <= p_q;
      if (cmd_i.scale || cmd_i.dinit)
        cnt_q <= '0;
      else if (cmd_i.sqrt_step || cmd_i.div_step)
        cnt_q <= cnt_q + CNTW'(1);
      if (cmd_i.emit) begin
        out_valid_q   <= 1'b1;
        out_q.pixel   <= bg_q ? cfg_i.background : sat_px;
        out_q.row_end <= last_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign sts_o.ray_end   = ray_end;
  assign sts_o.slice_sel = ssel_q;
  assign sts_o.tile_ok   = tile_ok;
  assign sts_o.sqrt_last = cnt_q == CNTW'(SW - 1);
  assign sts_o.div_last  = cnt_q == CNTW'(DIV_STEPS - 1);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// File: rtl/volume_surface_depth_shader.sv
// Voxels: one per cycle within a ray. At each ray end the block stalls for the
// distance memory read; pixel rays then add emit, and shaded tiles run
// diff, square, ftsum, scale, a root of DW+17 steps, divider setup, 32 divide steps,
// sum and emit (DW = clog2(MAX_RAY_LENGTH+1)); emit waits while an earlier result
// is still held. Reset clears the counters and control registers; the tile math
// registers and the distance memory are not cleared.
`timescale 1ns / 1ps

module volume_surface_depth_shader #(
  parameter int unsigned MAX_RAY_LENGTH = 1024,
  parameter int unsigned MAX_RAYS       = 512
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  vsds_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output vsds_pkg::out_t               out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vsds_pkg::PADDR_W-1:0] paddr,
  input  logic [vsds_pkg::PDATA_W-1:0] pwdata,
  output logic [vsds_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import vsds_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  vsds_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  vsds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vsds_dp #(
    .MAX_RAY_LENGTH (MAX_RAY_LENGTH),
    .MAX_RAYS       (MAX_RAYS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/vsds_chk.sv
// Port-level checker for the volume surface depth shader, bound to the top.
// Depends on vsds_pkg and volume_surface_depth_shader_assert.svh.
`timescale 1ns / 1ps
`include "volume_surface_depth_shader_assert.svh"

module vsds_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input vsds_pkg::out_t out_data_o,
  input logic           pready
);
  import vsds_pkg::*;

  `VSDS_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result dropped or changed while stalled")
  `VSDS_ASSERT_IMP(a_pready, 1'b1, pready, "pready low")
  `VSDS_ASSERT_IMP(a_emit_stall, $rose(out_valid_o), $past(!in_ready_o), "result loaded while intake open")
  `VSDS_ASSERT_IMP(a_known, 1'b1, !$isunknown({in_valid_i, in_ready_o, out_valid_o}), "X on handshake")

endmodule

bind volume_surface_depth_shader vsds_chk u_chk (.*);
